// ===== hw/rtl/ufp_pkg.sv =====
`default_nettype none

package ufp_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_VALUE,
    KIND_KEY_END,
    KIND_PAIR_END
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       qend;
  } res_t;

  // results caused by one input transaction
  typedef struct packed {
    res_t [MAX_RESULTS-1:0] slot;
    logic [CNT_W-1:0]       cnt;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ufp_if.sv =====
`default_nettype none

interface ufp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ufp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       run_last;
  logic       query_end;

  modport source (output valid, output out_byte, output kind, output run_last,
                  output query_end, input ready);
  modport sink (input valid, input out_byte, input kind, input run_last,
                input query_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ufp_front.sv =====
`default_nettype none

module ufp_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ufp_in_if.sink            in_i,
  input  wire logic         full_i,
  output logic              push_o,
  output ufp_pkg::cmd_t     push_data_o
);
  import ufp_pkg::*;

  logic       ivf_q, ivf_d;
  logic [1:0] pc_q, pc_d;
  logic [7:0] held_q, held_d;
  cmd_t       cmd;
  logic       accept;

  function automatic cmd_t push(cmd_t c, logic [7:0] b, kind_e k, logic q);
    cmd_t r;
    r = c;
    r.slot[c.cnt[SLOT_W-1:0]].data = b;
    r.slot[c.cnt[SLOT_W-1:0]].kind = k;
    r.slot[c.cnt[SLOT_W-1:0]].qend = q;
    r.cnt = c.cnt + CNT_W'(1);
    return r;
  endfunction

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] plain(logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  function automatic logic [7:0] decode_pair(logic [7:0] a, logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic [7:0] r;
    ha = hex_val(a);
    hb = hex_val(b);
    r  = 8'd0;
    if (ha[4]) begin
      r = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
    end else if (hb[4]) begin
      if (a == CH_SPACE || (a >= 8'h09 && a <= 8'h0D) || a == CH_PLUS) begin
        r = {4'd0, hb[3:0]};
      end else if (a == CH_MINUS) begin
        r = 8'd0 - {4'd0, hb[3:0]};
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [1:0] p;
    logic [7:0] h;
    kind_e      k;
    cmd    = '0;
    ivf_d  = ivf_q;
    pc_d   = pc_q;
    held_d = held_q;
    p      = pc_q;
    h      = held_q;
    k      = ivf_q ? KIND_VALUE : KIND_KEY;
    if (in_i.data_byte == CH_AMP) begin
      if (pc_q != 2'd0) cmd = push(cmd, CH_PCT, k, 1'b0);
      if (pc_q == 2'd2) cmd = push(cmd, plain(held_q), k, 1'b0);
      cmd    = push(cmd, 8'd0, KIND_PAIR_END, in_i.last_byte);
      pc_d   = 2'd0;
      held_d = 8'd0;
      ivf_d  = 1'b0;
    end else if (in_i.data_byte == CH_EQ && !ivf_q) begin
      if (pc_q != 2'd0) cmd = push(cmd, CH_PCT, k, 1'b0);
      if (pc_q == 2'd2) cmd = push(cmd, plain(held_q), k, 1'b0);
      cmd    = push(cmd, 8'd0, KIND_KEY_END, 1'b0);
      pc_d   = 2'd0;
      held_d = 8'd0;
      ivf_d  = 1'b1;
      if (in_i.last_byte) begin
        cmd   = push(cmd, 8'd0, KIND_PAIR_END, 1'b1);
        ivf_d = 1'b0;
      end
    end else begin
      if (pc_q == 2'd0) begin
        if (in_i.data_byte == CH_PCT) p = 2'd1;
        else cmd = push(cmd, plain(in_i.data_byte), k, 1'b0);
      end else if (pc_q == 2'd1) begin
        h = in_i.data_byte;
        p = 2'd2;
      end else begin
        cmd = push(cmd, decode_pair(held_q, in_i.data_byte), k, 1'b0);
        p   = 2'd0;
        h   = 8'd0;
      end
      if (in_i.last_byte) begin
        if (p != 2'd0) cmd = push(cmd, CH_PCT, k, 1'b0);
        if (p == 2'd2) cmd = push(cmd, plain(h), k, 1'b0);
        cmd   = push(cmd, 8'd0, KIND_PAIR_END, 1'b1);
        p     = 2'd0;
        h     = 8'd0;
        ivf_d = 1'b0;
      end
      pc_d   = p;
      held_d = h;
    end
  end

  assign in_i.ready  = !full_i;
  assign accept      = in_i.valid && !full_i;
  assign push_o      = accept && (cmd.cnt != '0);
  assign push_data_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivf_q  <= 1'b0;
      pc_q   <= 2'd0;
      held_q <= 8'd0;
    end else if (accept) begin
      ivf_q  <= ivf_d;
      pc_q   <= pc_d;
      held_q <= held_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pc_q != 2'd3)
    else $error("escape hold count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cmd.cnt <= CNT_W'(MAX_RESULTS)))
    else $error("too many results for one transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/ufp_fifo.sv =====
`default_nettype none

module ufp_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ufp_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output ufp_pkg::cmd_t      pop_data_o,
  output logic               empty_o
);
  import ufp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== hw/rtl/ufp_back.sv =====
`default_nettype none

module ufp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ufp_pkg::cmd_t cmd_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  ufp_out_if.source          out_o
);
  import ufp_pkg::*;

  cmd_t              cur_q;
  logic              cur_valid_q;
  logic [SLOT_W-1:0] idx_q;
  logic [CNT_W-1:0]  cnt_m1;
  logic              last_slot;
  logic              done;

  assign cnt_m1    = cur_q.cnt - CNT_W'(1);
  assign last_slot = ({1'b0, idx_q} == cnt_m1);
  assign done      = out_o.ready && last_slot;
  assign pop_o     = !empty_i && (!cur_valid_q || done);

  assign out_o.valid     = cur_valid_q;
  assign out_o.out_byte  = cur_q.slot[idx_q].data;
  assign out_o.kind      = cur_q.slot[idx_q].kind;
  assign out_o.query_end = cur_q.slot[idx_q].qend;
  assign out_o.run_last  = last_slot;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (cur_valid_q && out_o.ready) begin
      if (last_slot) cur_valid_q <= 1'b0;
      else idx_q <= idx_q + SLOT_W'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_q.cnt != '0 && {1'b0, idx_q} <= cnt_m1))
    else $error("result index beyond transaction result count");

endmodule

`default_nettype wire

// ===== hw/rtl/urlencoded_form_parser.sv =====
`default_nettype none

// channel  dir  payload                                 transaction
// in_i     in   data_byte[7:0] last_byte                valid && ready
// out_o    out  out_byte[7:0] kind[1:0] run_last        valid && ready
//               query_end
//
// one input byte a cycle while each byte gives at most one result and the output is ready
// a byte giving several results sends them out in turn; the queue absorbs it
// input ready drops only when the queue of QUEUE_DEPTH entries is full
// each byte's results pass through the queue, then the output register
// reset puts the decoder back in the key field with no escape held

module urlencoded_form_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ufp_in_if.sink    in_i,
  ufp_out_if.source out_o
);
  import ufp_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_data, pop_data;

  ufp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ufp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  ufp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pop_data),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_urlencoded_form_parser.sv =====
`timescale 1ns / 100ps

module tb_urlencoded_form_parser;
  import ufp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned RANDOM_ITEMS = 160;
  localparam int unsigned HOLD_OFF     = 120;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       run_last;
    logic       qend;
  } result_t;

  class form_scoreboard;
    bit       in_value;
    bit [1:0] esc_cnt;
    bit [7:0] esc_byte;
    result_t  expected_q[$];
    result_t  batch_q[$];
    int       n_errors;

    function new();
      in_value = 1'b0;
      esc_cnt  = 2'd0;
      esc_byte = 8'h00;
      n_errors = 0;
    endfunction

    function int hex_val(bit [7:0] ch);
      if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
      if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
      if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
      return -1;
    endfunction

    function bit is_space(bit [7:0] ch);
      return ch == CH_SPACE || (ch >= 8'h09 && ch <= 8'h0D);
    endfunction

    // strtol-style reading of the two bytes after a percent sign
    function bit [7:0] decode_escape(bit [7:0] a, bit [7:0] b);
      int ha;
      int hb;
      ha = hex_val(a);
      hb = hex_val(b);
      if (ha >= 0) return (hb >= 0) ? 8'(ha * 16 + hb) : 8'(ha);
      if (hb < 0) return 8'h00;
      if (is_space(a) || a == CH_PLUS) return 8'(hb);
      if (a == CH_MINUS) return 8'(256 - hb);
      return 8'h00;
    endfunction

    function bit [7:0] plain(bit [7:0] ch);
      return (ch == CH_PLUS) ? CH_SPACE : ch;
    endfunction

    function kind_e field_kind();
      return in_value ? KIND_VALUE : KIND_KEY;
    endfunction

    function void add(bit [7:0] data, kind_e kind, bit qend);
      result_t r;
      r.data     = data;
      r.kind     = kind;
      r.run_last = 1'b0;
      r.qend     = qend;
      batch_q    = {batch_q, r};
    endfunction

    // a cut-off escape comes out literally, a held plus as a space
    function void flush_escape();
      kind_e k;
      k = field_kind();
      if (esc_cnt >= 2'd1) add(CH_PCT, k, 1'b0);
      if (esc_cnt >= 2'd2) add(plain(esc_byte), k, 1'b0);
      esc_cnt  = 2'd0;
      esc_byte = 8'h00;
    endfunction

    function void note_input(bit [7:0] ch, bit last);
      kind_e k;
      batch_q.delete();
      k = field_kind();
      if (ch == CH_AMP) begin
        flush_escape();
        add(8'h00, KIND_PAIR_END, last);
        in_value = 1'b0;
      end else if (ch == CH_EQ && !in_value) begin
        flush_escape();
        add(8'h00, KIND_KEY_END, 1'b0);
        in_value = 1'b1;
        if (last) begin
          add(8'h00, KIND_PAIR_END, 1'b1);
          in_value = 1'b0;
        end
      end else begin
        if (esc_cnt == 2'd0) begin
          if (ch == CH_PCT) esc_cnt = 2'd1;
          else add(plain(ch), k, 1'b0);
        end else if (esc_cnt == 2'd1) begin
          esc_byte = ch;
          esc_cnt  = 2'd2;
        end else begin
          add(decode_escape(esc_byte, ch), k, 1'b0);
          esc_cnt  = 2'd0;
          esc_byte = 8'h00;
        end
        if (last) begin
          flush_escape();
          add(8'h00, KIND_PAIR_END, 1'b1);
          in_value = 1'b0;
        end
      end
      if (batch_q.size() > 0) batch_q[batch_q.size() - 1].run_last = 1'b1;
      expected_q = {expected_q, batch_q};
    endfunction

    function void check_result(logic [7:0] b, logic [1:0] k, logic rl, logic qe);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_byte %0h kind %0d", b, k);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      if (b !== want.data) begin
        $error("out_byte: expected %0h, actual %0h", want.data, b);
        n_errors++;
      end
      if (k !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, k);
        n_errors++;
      end
      if (rl !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, rl);
        n_errors++;
      end
      if (qe !== want.qend) begin
        $error("query_end: expected %0b, actual %0b", want.qend, qe);
        n_errors++;
      end
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  int             src_idle_pct  = 0;
  int             sink_idle_pct = 0;
  int             hold_cycles   = 0;
  int             items_sent    = 0;
  int unsigned    cycle_cnt     = 0;
  int unsigned    drain_cnt;
  form_scoreboard sb;

  ufp_in_if  in_bus ();
  ufp_out_if out_bus ();

  urlencoded_form_parser DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver, with a counted hold-off
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_bus.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_result(out_bus.out_byte, out_bus.kind, out_bus.run_last, out_bus.query_end);
  end

  task automatic send_byte(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.data_byte = ch;
    in_bus.last_byte = last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_input(ch, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(21);
    if (v < 10) return 8'(8'h30 + v);
    if (v < 16) return 8'(8'h61 + v - 10);
    return 8'(8'h41 + v - 16);
  endfunction

  function automatic logic random_last();
    return $urandom_range(24) == 0;
  endfunction

  task automatic send_token();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      if ($urandom_range(1) == 0) send_byte(hex_char(), random_last());
      else send_byte(8'(8'h67 + $urandom_range(19)), random_last());
    end else if (pick < 55) begin
      send_byte(CH_PCT, random_last());
      repeat (2) begin
        if ($urandom_range(99) < 85) send_byte(hex_char(), random_last());
        else send_byte(8'($urandom_range(255)), random_last());
      end
    end else if (pick < 62) begin
      send_byte(CH_PLUS, random_last());
    end else if (pick < 72) begin
      send_byte(CH_EQ, random_last());
    end else if (pick < 82) begin
      send_byte(CH_AMP, random_last());
    end else if (pick < 88) begin
      case ($urandom_range(2))
        0:       send_byte(CH_SPACE, random_last());
        1:       send_byte(8'(8'h09 + $urandom_range(4)), random_last());
        default: send_byte(CH_MINUS, random_last());
      endcase
    end else begin
      send_byte(8'($urandom_range(255)), random_last());
    end
  endtask

  initial begin
    sb               = new();
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.last_byte = 1'b0;
    src_idle_pct     = 26;
    sink_idle_pct    = 86;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // escape forms, then a cut-off escape holding a plus on the last byte
    send_text("%41%4g=%+F%-1%z5", 1'b0);
    send_text("%+", 1'b1);
    // empty pair, key without equals, byte extremes, equals inside a value
    send_text("&a%&", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_EQ, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_EQ, 1'b0);
    send_byte(CH_AMP, 1'b1);
    send_byte(CH_EQ, 1'b1);

    while (items_sent < RANDOM_ITEMS / 3) send_token();
    src_idle_pct  = 86;
    sink_idle_pct = 26;
    while (items_sent < 2 * RANDOM_ITEMS / 3) send_token();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_cycles   = HOLD_OFF;
    while (items_sent < RANDOM_ITEMS) send_token();
    in_bus.valid = 1'b0;

    drain_cnt = 0;
    while (sb.waiting() != 0 && drain_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cnt++;
    end
    repeat (10) @(posedge clk);
    if (sb.waiting() != 0)
      $error("%0d expected results never arrived", sb.waiting());

    if (sb.n_errors == 0 && sb.waiting() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
